// ===== rtl/pcm_pkg.sv =====
// Shared types and constants for the permutation crossover/mutate block.
// No dependencies; imported by permutation_crossover_mutate.
`timescale 1ns / 1ps

package pcm_pkg;

  localparam int MAX_TOUR = 32;
  localparam int ADDR_W   = $clog2(MAX_TOUR);
  localparam int CITY_W   = 5;
  localparam int CNT_W    = $clog2(MAX_TOUR + 1);

  localparam logic [CNT_W-1:0] CITY_COUNT_RST = CNT_W'(10);
  localparam logic [CNT_W-1:0] TOUR_MIN       = CNT_W'(2);
  localparam logic [CNT_W-1:0] TOUR_MAX       = CNT_W'(MAX_TOUR);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FILL_RD,
    ST_FILL_USE,
    ST_FILL_END,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage

// ===== rtl/permutation_crossover_mutate.sv =====
// Position-based crossover of two parent tours with an adjacent-swap mutation.
// Depends on pcm_pkg for widths, the tour limit and the sequencer states.
//
//   channel | dir | tdata (low bit up)                        | tuser / tlast
//   in_     | in  | first[4:0] second[9:5] swap_pos[14:10]    | tuser = keep bit
//   out_    | out | child_city[4:0]                           | tuser = valid, tlast = last
//   cfg_    | in  | city_count[5:0]                           | write enable only
//
// Loading takes one transfer per cycle. After the final item of a child the
// fill pass reads the second-parent memory in ST_FILL_RD and uses the city in
// ST_FILL_USE for each position, stays in ST_FILL_USE for each filled position
// skipped, and closes in ST_FILL_END; emission reads the child memory in
// ST_EMIT_RD and loads the output register in ST_EMIT_LD for each city. The
// input stays closed during fill and emission.
// Reset (rst_n low, synchronous) sets city_count to 10 and empties the loader.
// A stalled output holds its register and the sequencer; the input reopens
// only once the last city of the child sits in the output register.
`timescale 1ns / 1ps

module permutation_crossover_mutate
  import pcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wdata,     // city_count
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // first_parent_city, second_parent_city, swap_position
  input  logic        in_tuser,      // keep_from_first
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // child_city
  output logic        out_tuser,     // valid_res
  output logic        out_tlast      // last_city
);

  // memories: second parent and child tour
  logic [CITY_W-1:0] sp_mem    [MAX_TOUR];
  logic [CITY_W-1:0] child_mem [MAX_TOUR];
  logic [CITY_W-1:0] sp_q_r;
  logic [CITY_W-1:0] child_q_r;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     city_count_r, city_count_nxt;
  logic [CNT_W-1:0]     loaded_r, loaded_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     place_r, place_nxt;
  logic [MAX_TOUR-1:0]  present_r, present_nxt;
  logic [MAX_TOUR-1:0]  filled_r, filled_nxt;
  logic                 ok_r, ok_nxt;
  logic [ADDR_W-1:0]    swap_r, swap_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CITY_W-1:0]    out_city_r, out_city_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_ok_r, out_ok_nxt;

  logic [CNT_W-1:0]     tour_len;
  logic [CNT_W-1:0]     last_idx;
  logic [MAX_TOUR:0]    len_mask_full;
  logic [MAX_TOUR-1:0]  len_mask;

  logic [CITY_W-1:0]    in_first;
  logic [CITY_W-1:0]    in_second;
  logic [CITY_W-1:0]    in_swap;
  logic                 in_fire;
  logic [CNT_W-1:0]     load_idx;
  logic [MAX_TOUR-1:0]  present_base;
  logic [MAX_TOUR-1:0]  filled_base;
  logic                 ok_base;

  logic                 child_we;
  logic [ADDR_W-1:0]    child_waddr;
  logic [CITY_W-1:0]    child_wdata;
  logic                 sp_we;
  logic                 sp_rd_en;
  logic                 child_rd_en;
  logic [ADDR_W-1:0]    child_raddr;
  logic [ADDR_W-1:0]    swap_next;
  logic [ADDR_W-1:0]    emit_pos;
  logic                 elig;

  // unpack the input transfer
  assign in_first  = in_tdata[4:0];
  assign in_second = in_tdata[9:5];
  assign in_swap   = in_tdata[14:10];

  // clamp the tour length and build the mask of live positions
  always_comb begin
    if (city_count_r < TOUR_MIN) begin
      tour_len = TOUR_MIN;
    end else if (city_count_r > TOUR_MAX) begin
      tour_len = TOUR_MAX;
    end else begin
      tour_len = city_count_r;
    end
    last_idx      = tour_len - CNT_W'(1);
    len_mask_full = ((MAX_TOUR+1)'(1) << tour_len) - (MAX_TOUR+1)'(1);
    len_mask      = len_mask_full[MAX_TOUR-1:0];
  end

  assign in_tready = (state_r == ST_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign load_idx  = (loaded_r >= tour_len) ? '0 : loaded_r;

  // start a fresh child on position zero
  assign present_base = (load_idx == '0) ? '0 : present_r;
  assign filled_base  = (load_idx == '0) ? '0 : filled_r;
  assign ok_base      = (load_idx == '0) ? 1'b1 : ok_r;

  // swap partner and remapped emit address
  assign swap_next = (CNT_W'(swap_r) == last_idx) ? '0 : swap_r + ADDR_W'(1);
  assign emit_pos  = idx_r[ADDR_W-1:0];
  always_comb begin
    if (emit_pos == swap_r) begin
      child_raddr = swap_next;
    end else if (emit_pos == swap_next) begin
      child_raddr = swap_r;
    end else begin
      child_raddr = emit_pos;
    end
  end

  assign elig = (CNT_W'(sp_q_r) < tour_len) && !present_r[sp_q_r];

  // sequencer: load, fill from second parent, emit
  always_comb begin
    state_nxt      = state_r;
    city_count_nxt = city_count_r;
    loaded_nxt     = loaded_r;
    idx_nxt        = idx_r;
    place_nxt      = place_r;
    present_nxt    = present_r;
    filled_nxt     = filled_r;
    ok_nxt         = ok_r;
    swap_nxt       = swap_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_city_nxt   = out_city_r;
    out_last_nxt   = out_last_r;
    out_ok_nxt     = out_ok_r;
    child_we       = 1'b0;
    child_waddr    = load_idx[ADDR_W-1:0];
    child_wdata    = '0;
    sp_we          = 1'b0;
    sp_rd_en       = 1'b0;
    child_rd_en    = 1'b0;

    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          // store second parent, place kept cities right away
          sp_we       = 1'b1;
          child_we    = 1'b1;
          child_waddr = load_idx[ADDR_W-1:0];
          child_wdata = in_tuser ? in_first : '0;
          present_nxt = present_base;
          filled_nxt  = filled_base;
          ok_nxt      = ok_base;
          if (in_tuser) begin
            filled_nxt[load_idx[ADDR_W-1:0]] = 1'b1;
            present_nxt[in_first]            = 1'b1;
            if ((CNT_W'(in_first) >= tour_len) || present_base[in_first]) begin
              ok_nxt = 1'b0;
            end
          end
          if (load_idx == last_idx) begin
            loaded_nxt = '0;
            idx_nxt    = '0;
            place_nxt  = '0;
            swap_nxt   = (CNT_W'(in_swap) > last_idx) ? last_idx[ADDR_W-1:0] : in_swap;
            state_nxt  = ST_FILL_RD;
          end else begin
            loaded_nxt = load_idx + CNT_W'(1);
          end
        end
      end

      ST_FILL_RD: begin
        sp_rd_en  = 1'b1;
        state_nxt = ST_FILL_USE;
      end

      ST_FILL_USE: begin
        if (!elig) begin
          // skip cities out of range or already present
          if (idx_r == last_idx) begin
            state_nxt = ST_FILL_END;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_FILL_RD;
          end
        end else if (place_r >= tour_len) begin
          state_nxt = ST_FILL_END;
        end else if (filled_r[place_r[ADDR_W-1:0]]) begin
          place_nxt = place_r + CNT_W'(1);
        end else begin
          child_we                          = 1'b1;
          child_waddr                       = place_r[ADDR_W-1:0];
          child_wdata                       = sp_q_r;
          filled_nxt[place_r[ADDR_W-1:0]]   = 1'b1;
          present_nxt[sp_q_r]               = 1'b1;
          place_nxt                         = place_r + CNT_W'(1);
          if (idx_r == last_idx) begin
            state_nxt = ST_FILL_END;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_FILL_RD;
          end
        end
      end

      ST_FILL_END: begin
        // any unfilled position spoils the child
        if (filled_r != len_mask) begin
          ok_nxt = 1'b0;
        end
        idx_nxt   = '0;
        state_nxt = ST_EMIT_RD;
      end

      ST_EMIT_RD: begin
        if (!out_valid_r || out_tready) begin
          child_rd_en = 1'b1;
          state_nxt   = ST_EMIT_LD;
        end
      end

      ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_city_nxt  = child_q_r;
        out_last_nxt  = (idx_r == last_idx);
        out_ok_nxt    = ok_r;
        if (idx_r == last_idx) begin
          state_nxt = ST_LOAD;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = ST_EMIT_RD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    // configuration write drops any partial child
    if (cfg_wr_en) begin
      city_count_nxt = cfg_wdata;
      loaded_nxt     = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      city_count_r <= CITY_COUNT_RST;
      loaded_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      city_count_r <= city_count_nxt;
      loaded_r     <= loaded_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    place_r    <= place_nxt;
    present_r  <= present_nxt;
    filled_r   <= filled_nxt;
    ok_r       <= ok_nxt;
    swap_r     <= swap_nxt;
    out_city_r <= out_city_nxt;
    out_last_r <= out_last_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  // second-parent memory
  always_ff @(posedge clk) begin
    if (sp_we) begin
      sp_mem[load_idx[ADDR_W-1:0]] <= in_second;
    end
    if (sp_rd_en) begin
      sp_q_r <= sp_mem[idx_r[ADDR_W-1:0]];
    end
  end

  // child memory
  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
    if (child_rd_en) begin
      child_q_r <= child_mem[child_raddr];
    end
  end

  // result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8-CITY_W){1'b0}}, out_city_r};
  assign out_tuser  = out_ok_r;
  assign out_tlast  = out_last_r;

endmodule
